// ===== src/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// stq_pkg: shared types and constants of the sorted one-shot timer queue
// Request and response structs, operation and result codes, sequencer states.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int NumTimersDef = 16;
    localparam int TimeBitsDef  = 32;

    // A tick reports at most this many fired timers.
    localparam int MaxOut       = 16;
    localparam int NFIRED_W     = $clog2(MaxOut + 1);

    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_DEL   = 2'd1,
        FUNC_REARM = 2'd2,
        FUNC_TICK  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        KIND_ARMED = 2'd0,
        KIND_DEL   = 2'd1,
        KIND_FIRED = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef struct packed {
        t_func       func;
        logic [3:0]  timer_id;
        logic [31:0] expiry;
        logic [31:0] now;
    } t_req;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] fired_id;
        logic       cancelled;
        logic       last;
    } t_rsp;

    typedef enum logic [1:0] {
        LIST_NONE,
        LIST_INSERT,
        LIST_REMOVE
    } t_list_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_INSERT,
        ST_RESP,
        ST_TICK_RD,
        ST_TICK_CMP
    } t_state;

endpackage

// ===== src/stq_order_list.sv =====
// ----------------------------------------------------------------------------
// stq_order_list: sorted list of timer slots
// Register line that opens a gap for an insert or closes one on a remove,
// with one read port at a sequencer-chosen position.
// ----------------------------------------------------------------------------
module stq_order_list
    import stq_pkg::*;
#(
    parameter int NUM_TIMERS = NumTimersDef,
    localparam int IDX_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  logic             i_clk,
    input  t_list_op         i_op,
    input  logic [IDX_W-1:0] i_pos,
    input  logic [IDX_W-1:0] i_slot,
    input  logic [IDX_W-1:0] i_rd_idx,
    output logic [IDX_W-1:0] o_rd_slot
);

    logic [IDX_W-1:0] r_list [NUM_TIMERS];
    logic [IDX_W-1:0] n_list [NUM_TIMERS];

    always_comb begin
        n_list = r_list;
        unique case (i_op)
            LIST_NONE: begin
            end
            LIST_INSERT: begin
                if (i_pos == '0) begin
                    n_list[0] = i_slot;
                end
                for (int i = 1; i < NUM_TIMERS; i++) begin
                    if (IDX_W'(i) > i_pos) begin
                        n_list[i] = r_list[i-1];
                    end else if (IDX_W'(i) == i_pos) begin
                        n_list[i] = i_slot;
                    end
                end
            end
            LIST_REMOVE: begin
                for (int i = 0; i < NUM_TIMERS - 1; i++) begin
                    if (IDX_W'(i) >= i_pos) begin
                        n_list[i] = r_list[i+1];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_list <= n_list;
    end

    assign o_rd_slot = r_list[i_rd_idx];

endmodule

// ===== src/sorted_oneshot_timer_queue_top.sv =====
// ----------------------------------------------------------------------------
// sorted_oneshot_timer_queue_top: sorted list of one-shot timers
// Add, delete, re-arm and tick requests on a list kept in expiry order,
// walked one entry at a time, with one expiry comparison per step.
// ----------------------------------------------------------------------------
//  Channel   Ports                    Handshake
//  request   i_req (t_req)            taken when start is high and busy is low
//  response  o_rsp (t_rsp), o_strobe  one cycle per result, cannot be held off
//
//  Add / re-arm: find the old entry if the timer is armed, then an expiry
//  read and a compare per list entry up to the insert point, then the insert.
//  Delete: find the entry and remove it. Tick: a read and a compare per fired timer.
//  The expiry memory's one read port keeps the walk to one list entry per step.
//  Reset clears the pending count and the armed flags; no clearing pass runs.
//  Results leave as one-cycle strobes; the receiver cannot stall the block.
// ----------------------------------------------------------------------------
module sorted_oneshot_timer_queue_top
    import stq_pkg::*;
#(
    parameter int NUM_TIMERS = NumTimersDef,
    parameter int TIME_BITS  = TimeBitsDef
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_strobe,
    output t_rsp o_rsp
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W = $clog2(NUM_TIMERS + 1);

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_idx, n_idx;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [NUM_TIMERS-1:0] r_armed, n_armed;
    logic                 r_canc, n_canc;
    logic [IDX_W-1:0]     r_held_slot, n_held_slot;
    logic                 r_has_held, n_has_held;
    logic [NFIRED_W-1:0]  r_nfired, n_nfired;
    logic                 r_strobe, n_strobe;
    t_rsp                 r_rsp, n_rsp;

    t_func                r_func;
    logic [3:0]           r_id;
    logic [IDX_W-1:0]     r_slot;
    logic [TIME_BITS-1:0] r_exp;
    logic [TIME_BITS-1:0] r_now;

    logic [TIME_BITS-1:0] r_exp_mem [NUM_TIMERS];
    logic [TIME_BITS-1:0] r_rd_exp;
    logic                 exp_we;

    t_list_op             list_op;
    logic [IDX_W-1:0]     list_pos;
    logic [IDX_W-1:0]     rd_slot;

    logic                 accept;
    logic                 in_valid;
    logic [IDX_W+3:0]     id_wide;
    logic [IDX_W-1:0]     in_slot;
    logic [TIME_BITS+31:0] exp_wide;
    logic [TIME_BITS+31:0] now_wide;
    logic [IDX_W+3:0]     held_wide;
    logic [3:0]           held_id;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign in_valid = (32'(i_req.timer_id) < 32'(NUM_TIMERS));
    assign id_wide  = {IDX_W'(0), i_req.timer_id};
    assign in_slot  = id_wide[IDX_W-1:0];
    assign exp_wide = {TIME_BITS'(0), i_req.expiry};
    assign now_wide = {TIME_BITS'(0), i_req.now};
    assign held_wide = {4'd0, r_held_slot};
    assign held_id  = held_wide[3:0];

    stq_order_list #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_order_list (
        .i_clk     (i_clk),
        .i_op      (list_op),
        .i_pos     (list_pos),
        .i_slot    (r_slot),
        .i_rd_idx  (r_idx[IDX_W-1:0]),
        .o_rd_slot (rd_slot)
    );

    // Expiry store: read address follows the list entry under the walk index.
    always_ff @(posedge i_clk) begin
        if (exp_we) begin
            r_exp_mem[r_slot] <= r_exp;
        end
        r_rd_exp <= r_exp_mem[rd_slot];
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_armed     = r_armed;
        n_canc      = r_canc;
        n_held_slot = r_held_slot;
        n_has_held  = r_has_held;
        n_nfired    = r_nfired;
        n_strobe    = 1'b0;
        n_rsp       = r_rsp;
        list_op     = LIST_NONE;
        list_pos    = r_idx[IDX_W-1:0];
        exp_we      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_idx      = '0;
                    n_nfired   = '0;
                    n_has_held = 1'b0;
                    n_canc     = 1'b0;
                    unique case (i_req.func)
                        FUNC_ADD, FUNC_REARM: begin
                            if (!in_valid) begin
                                n_state = ST_RESP;
                            end else if (r_armed[in_slot]) begin
                                n_state = ST_FIND;
                            end else begin
                                n_state = ST_SCAN_RD;
                            end
                        end
                        FUNC_DEL: begin
                            if (in_valid && r_armed[in_slot]) begin
                                n_state = ST_FIND;
                            end else begin
                                n_state = ST_RESP;
                            end
                        end
                        FUNC_TICK: begin
                            n_state = ST_TICK_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_FIND: begin
                if (r_idx != r_cnt && rd_slot != r_slot) begin
                    n_idx = r_idx + 1'b1;
                end else begin
                    if (r_idx != r_cnt) begin
                        list_op = LIST_REMOVE;
                        n_cnt   = r_cnt - 1'b1;
                    end
                    n_armed[r_slot] = 1'b0;
                    if (r_func == FUNC_DEL) begin
                        n_canc  = 1'b1;
                        n_state = ST_RESP;
                    end else begin
                        n_idx   = '0;
                        n_state = ST_SCAN_RD;
                    end
                end
            end

            ST_SCAN_RD: begin
                if (r_idx == r_cnt) begin
                    n_state = ST_INSERT;
                end else begin
                    n_state = ST_SCAN_CMP;
                end
            end

            ST_SCAN_CMP: begin
                // Equal expiries go behind those already in the list.
                if (r_exp < r_rd_exp) begin
                    n_state = ST_INSERT;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_SCAN_RD;
                end
            end

            ST_INSERT: begin
                list_op         = LIST_INSERT;
                exp_we          = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                n_armed[r_slot] = 1'b1;
                n_state         = ST_RESP;
            end

            ST_RESP: begin
                n_strobe        = 1'b1;
                n_rsp.kind      = (r_func == FUNC_DEL) ? KIND_DEL : KIND_ARMED;
                n_rsp.fired_id  = r_id;
                n_rsp.cancelled = (r_func == FUNC_DEL) ? r_canc : 1'b0;
                n_rsp.last      = 1'b1;
                n_state         = ST_IDLE;
            end

            ST_TICK_RD: begin
                if (r_cnt == '0 || r_nfired == NFIRED_W'(MaxOut)) begin
                    n_strobe        = 1'b1;
                    n_rsp.kind      = r_has_held ? KIND_FIRED : KIND_NONE;
                    n_rsp.fired_id  = r_has_held ? held_id : 4'd0;
                    n_rsp.cancelled = 1'b0;
                    n_rsp.last      = 1'b1;
                    n_state         = ST_IDLE;
                end else begin
                    n_state = ST_TICK_CMP;
                end
            end

            ST_TICK_CMP: begin
                // A fired timer is held back one step so that its last flag
                // is known when it leaves.
                if (!(r_rd_exp > r_now)) begin
                    if (r_has_held) begin
                        n_strobe        = 1'b1;
                        n_rsp.kind      = KIND_FIRED;
                        n_rsp.fired_id  = held_id;
                        n_rsp.cancelled = 1'b0;
                        n_rsp.last      = 1'b0;
                    end
                    n_held_slot      = rd_slot;
                    n_has_held       = 1'b1;
                    list_op          = LIST_REMOVE;
                    list_pos         = '0;
                    n_cnt            = r_cnt - 1'b1;
                    n_armed[rd_slot] = 1'b0;
                    n_nfired         = r_nfired + 1'b1;
                    n_state          = ST_TICK_RD;
                end else begin
                    n_strobe        = 1'b1;
                    n_rsp.kind      = r_has_held ? KIND_FIRED : KIND_NONE;
                    n_rsp.fired_id  = r_has_held ? held_id : 4'd0;
                    n_rsp.cancelled = 1'b0;
                    n_rsp.last      = 1'b1;
                    n_state         = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cnt      <= '0;
            r_armed    <= '0;
            r_strobe   <= 1'b0;
            r_has_held <= 1'b0;
            r_idx      <= '0;
            r_nfired   <= '0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_armed    <= n_armed;
            r_strobe   <= n_strobe;
            r_has_held <= n_has_held;
            r_idx      <= n_idx;
            r_nfired   <= n_nfired;
        end
    end

    always_ff @(posedge i_clk) begin
        r_canc      <= n_canc;
        r_held_slot <= n_held_slot;
        r_rsp       <= n_rsp;
        if (accept) begin
            r_func <= i_req.func;
            r_id   <= i_req.timer_id;
            r_slot <= in_slot;
            r_exp  <= exp_wide[TIME_BITS-1:0];
            r_now  <= now_wide[TIME_BITS-1:0];
        end
    end

    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

// ===== tb/timer_queue_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timer_queue_checker: response checker of the sorted one-shot timer queue
// Keeps its own sorted timer list, works out the responses of every accepted
// request and compares each strobed response with the oldest one awaited.
// ----------------------------------------------------------------------------
module timer_queue_checker
    import stq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_busy,
    input  t_req i_req,
    input  logic i_strobe,
    input  t_rsp i_rsp,
    output int   o_fail_count,
    output int   o_outstanding
);

    localparam int ReportLimit = 10;

    logic [3:0]  sorted_ids  [NumTimersDef];
    logic [31:0] slot_expiry [NumTimersDef];
    bit          slot_armed  [NumTimersDef];
    int          live_count;

    t_rsp timer_events_due[$];
    t_rsp head_event;
    int   fail_total;

    function automatic void unlink_slot(logic [3:0] id);
        int pos;
        pos = -1;
        for (int i = 0; i < live_count; i++) begin
            if (pos < 0 && sorted_ids[i] == id) begin
                pos = i;
            end
        end
        if (pos >= 0) begin
            for (int j = pos; j + 1 < live_count; j++) begin
                sorted_ids[j] = sorted_ids[j + 1];
            end
            live_count--;
        end
        slot_armed[id] = 1'b0;
    endfunction

    function automatic void advance_timer_list(t_req req);
        t_rsp ev;
        int   pos;
        int   fired;
        ev = '0;
        ev.last = 1'b1;
        case (req.func)
            FUNC_ADD, FUNC_REARM: begin
                // Arming an armed timer moves it behind any equal expiries.
                if (slot_armed[req.timer_id]) begin
                    unlink_slot(req.timer_id);
                end
                pos = 0;
                while (pos < live_count && !(req.expiry < slot_expiry[sorted_ids[pos]])) begin
                    pos++;
                end
                for (int j = live_count; j > pos; j--) begin
                    sorted_ids[j] = sorted_ids[j - 1];
                end
                sorted_ids[pos] = req.timer_id;
                live_count++;
                slot_expiry[req.timer_id] = req.expiry;
                slot_armed[req.timer_id]  = 1'b1;
                ev.kind     = KIND_ARMED;
                ev.fired_id = req.timer_id;
                timer_events_due.push_back(ev);
            end
            FUNC_DEL: begin
                ev.kind     = KIND_DEL;
                ev.fired_id = req.timer_id;
                if (slot_armed[req.timer_id]) begin
                    unlink_slot(req.timer_id);
                    ev.cancelled = 1'b1;
                end
                timer_events_due.push_back(ev);
            end
            FUNC_TICK: begin
                fired = 0;
                while (fired < MaxOut && live_count > 0
                       && !(slot_expiry[sorted_ids[0]] > req.now)) begin
                    ev.kind     = KIND_FIRED;
                    ev.fired_id = sorted_ids[0];
                    ev.last     = 1'b0;
                    unlink_slot(sorted_ids[0]);
                    timer_events_due.push_back(ev);
                    fired++;
                end
                if (fired == 0) begin
                    ev.kind     = KIND_NONE;
                    ev.fired_id = '0;
                    ev.last     = 1'b1;
                    timer_events_due.push_back(ev);
                end else begin
                    ev = timer_events_due.pop_back();
                    ev.last = 1'b1;
                    timer_events_due.push_back(ev);
                end
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            live_count = 0;
            for (int i = 0; i < NumTimersDef; i++) begin
                slot_armed[i] = 1'b0;
            end
            timer_events_due.delete();
        end else begin
            // A response belongs to an earlier request, so check before predicting.
            if (i_strobe) begin
                if (timer_events_due.size() == 0) begin
                    if (fail_total < ReportLimit) begin
                        $display("unexpected response: kind %0d id %0d cancelled %0b last %0b",
                                 i_rsp.kind, i_rsp.fired_id, i_rsp.cancelled, i_rsp.last);
                    end
                    fail_total++;
                end else begin
                    head_event = timer_events_due.pop_front();
                    if (i_rsp.kind !== head_event.kind || i_rsp.fired_id !== head_event.fired_id
                        || i_rsp.cancelled !== head_event.cancelled
                        || i_rsp.last !== head_event.last) begin
                        if (fail_total < ReportLimit) begin
                            $display("response mismatch: expected kind %0d id %0d cancelled %0b %s",
                                     head_event.kind, head_event.fired_id,
                                     head_event.cancelled,
                                     $sformatf("last %0b, got kind %0d id %0d cancelled %0b last %0b",
                                               head_event.last, i_rsp.kind, i_rsp.fired_id,
                                               i_rsp.cancelled, i_rsp.last));
                        end
                        fail_total++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                advance_timer_list(i_req);
            end
        end
        o_fail_count  <= fail_total;
        o_outstanding <= timer_events_due.size();
    end

endmodule

// ===== tb/sorted_oneshot_timer_queue_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_oneshot_timer_queue_top_test: testbench of the sorted timer queue
// Sends directed and random add, delete, re-arm and tick requests with random
// sender gaps; a checker beside the block predicts and compares responses.
// ----------------------------------------------------------------------------
module sorted_oneshot_timer_queue_top_test
    import stq_pkg::*;
();

    localparam int RandomItems   = 260;
    localparam int WatchdogLimit = 3000;
    localparam int SettleCycles  = 80;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_strobe;
    t_rsp o_rsp;

    int fail_count;
    int outstanding;
    int quiet_cycles = 0;
    bit idling_on = 1'b1;

    sorted_oneshot_timer_queue_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_strobe(o_strobe),
        .o_rsp   (o_rsp)
    );

    timer_queue_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_strobe     (o_strobe),
        .i_rsp        (o_rsp),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Ends the run when neither a request nor a response moves for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WatchdogLimit) begin
            $display("sorted_oneshot_timer_queue_top_test failed");
            $finish;
        end
    end

    function automatic t_req make_req(t_func func, logic [3:0] id, logic [31:0] expiry,
                                      logic [31:0] now);
        t_req req;
        req.func     = func;
        req.timer_id = id;
        req.expiry   = expiry;
        req.now      = now;
        return req;
    endfunction

    // Called at a rising edge; returns at the edge where the request was taken, or after a random idle gap.
    task automatic issue(input t_req req);
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy);
        if (idling_on && $urandom_range(0, 99) < 16) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    initial begin
        t_req        req;
        int          roll;
        logic [31:0] clock_now;

        i_rst_n = 1'b0;
        start   = 1'b0;
        i_req   = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty list, delete of an idle timer, then the expiry extremes.
        issue(make_req(FUNC_TICK, 4'd0, $urandom, 32'd0));
        issue(make_req(FUNC_DEL, 4'd3, $urandom, $urandom));
        issue(make_req(FUNC_ADD, 4'd0, 32'd0, $urandom));
        issue(make_req(FUNC_ADD, 4'd15, 32'hFFFF_FFFF, $urandom));
        // Re-arm of an idle timer, equal expiries, and add of an armed timer.
        issue(make_req(FUNC_REARM, 4'd5, 32'd100, $urandom));
        issue(make_req(FUNC_ADD, 4'd6, 32'd100, $urandom));
        issue(make_req(FUNC_ADD, 4'd5, 32'd100, $urandom));
        issue(make_req(FUNC_TICK, 4'($urandom), $urandom, 32'd0));
        issue(make_req(FUNC_TICK, 4'($urandom), $urandom, 32'd100));
        issue(make_req(FUNC_DEL, 4'd15, $urandom, $urandom));
        // Every slot armed at once, then one tick that fires them all.
        for (int id = 0; id < NumTimersDef; id++) begin
            issue(make_req(FUNC_ADD, 4'(id), (id == 7) ? 32'hFFFF_FFFF : $urandom, $urandom));
        end
        issue(make_req(FUNC_TICK, 4'($urandom), $urandom, 32'hFFFF_FFFF));

        clock_now = $urandom;
        for (int n = 0; n < RandomItems; n++) begin
            idling_on = !(n >= 60 && n < 120);
            if (n == 130) begin
                wait_drained();
            end
            req.timer_id = 4'($urandom_range(0, 15));
            req.expiry   = $urandom;
            req.now      = $urandom;
            roll = $urandom_range(0, 99);
            if (roll < 34) begin
                req.func = FUNC_ADD;
            end else if (roll < 48) begin
                req.func = FUNC_DEL;
            end else if (roll < 62) begin
                req.func = FUNC_REARM;
            end else begin
                req.func = FUNC_TICK;
            end
            // Most requests follow a running time base; the rest use raw values.
            if ($urandom_range(0, 9) != 0) begin
                if (req.func == FUNC_TICK) begin
                    clock_now = clock_now + $urandom_range(0, 24);
                    req.now   = clock_now;
                end else begin
                    req.expiry = clock_now + $urandom_range(1, 80);
                end
            end
            issue(req);
        end

        wait_drained();
        repeat (SettleCycles) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("sorted_oneshot_timer_queue_top_test passed");
        end else begin
            $display("sorted_oneshot_timer_queue_top_test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/stq_pkg.sv
src/stq_order_list.sv
src/sorted_oneshot_timer_queue_top.sv
tb/timer_queue_checker.sv
tb/sorted_oneshot_timer_queue_top_test.sv
